/* rtl/cdcc_pkg.sv */
// Shared constants, opcodes, sense codes and the check result type for the command checker.
package cdcc_pkg;

  localparam int BLOCK_BYTES        = 2048;
  localparam int MAX_TRANSFER_BYTES = 16777216;
  localparam int MAX_READ_BLOCKS    = 8192;
  localparam int MAX_BLOCKS =
      (MAX_TRANSFER_BYTES / BLOCK_BYTES < MAX_READ_BLOCKS) ?
      (MAX_TRANSFER_BYTES / BLOCK_BYTES) : MAX_READ_BLOCKS;

  localparam int SENSE_BYTES = 18;

  localparam int IN_WIDTH  = 96;
  localparam int OUT_WIDTH = 80;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
  localparam logic [7:0] OP_READ6           = 8'h08;
  localparam logic [7:0] OP_SEEK6           = 8'h0B;
  localparam logic [7:0] OP_INQUIRY         = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
  localparam logic [7:0] OP_START_STOP      = 8'h1B;
  localparam logic [7:0] OP_PREVENT         = 8'h1E;
  localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_SEEK10          = 8'h2B;
  localparam logic [7:0] OP_READ_SUBCHANNEL = 8'h42;
  localparam logic [7:0] OP_READ_TOC        = 8'h43;
  localparam logic [7:0] OP_READ_HEADER     = 8'h44;
  localparam logic [7:0] OP_GET_CONFIG      = 8'h46;
  localparam logic [7:0] OP_EVENT_STATUS    = 8'h4A;
  localparam logic [7:0] OP_DISC_INFO       = 8'h51;
  localparam logic [7:0] OP_TRACK_INFO      = 8'h52;
  localparam logic [7:0] OP_MODE_SENSE10    = 8'h5A;
  localparam logic [7:0] OP_READ12          = 8'hA8;
  localparam logic [7:0] OP_MECH_STATUS     = 8'hBD;

  localparam logic [1:0] KEY_NONE      = 2'd0;
  localparam logic [1:0] KEY_NOT_READY = 2'd1;
  localparam logic [1:0] KEY_ILLEGAL   = 2'd2;

  localparam logic [2:0] CODE_NONE       = 3'd0;
  localparam logic [2:0] CODE_NO_MEDIUM  = 3'd1;
  localparam logic [2:0] CODE_LBA_RANGE  = 3'd2;
  localparam logic [2:0] CODE_INV_FIELD  = 3'd3;
  localparam logic [2:0] CODE_ILLEGAL_OP = 3'd4;

  localparam logic [0:0] REG_DISC_BLOCKS = 1'b0;

  typedef struct packed {
    logic [1:0] key;
    logic [2:0] code;
  } sense_t;

  typedef struct packed {
    logic        check_condition;
    sense_t      sense;
    logic        data_in;
    logic [31:0] start_lba;
    logic [13:0] block_count;
    logic [24:0] data_length;
  } result_t;

endpackage

/* rtl/cdcc_check.sv */
// Combinational decode and check of one command block against disc size and held sense.
module cdcc_check (
  input  logic [63:0]     cdb_head,
  input  logic [31:0]     cdb_tail,
  input  logic [31:0]     disc_blocks,
  input  cdcc_pkg::sense_t held,
  output cdcc_pkg::result_t res,
  output cdcc_pkg::sense_t held_next
);

  logic [7:0] op, b1, b2, b3, b4, b5, b6, b7, b8, b9;

  assign op = cdb_head[63:56];
  assign b1 = cdb_head[55:48];
  assign b2 = cdb_head[47:40];
  assign b3 = cdb_head[39:32];
  assign b4 = cdb_head[31:24];
  assign b5 = cdb_head[23:16];
  assign b6 = cdb_head[15:8];
  assign b7 = cdb_head[7:0];
  assign b8 = cdb_tail[31:24];
  assign b9 = cdb_tail[23:16];

  logic needs_medium;

  always_comb begin
    unique case (op) inside
      cdcc_pkg::OP_TEST_UNIT_READY, cdcc_pkg::OP_READ_CAPACITY, cdcc_pkg::OP_READ6,
      cdcc_pkg::OP_READ10, cdcc_pkg::OP_READ12, cdcc_pkg::OP_SEEK6, cdcc_pkg::OP_SEEK10,
      cdcc_pkg::OP_READ_SUBCHANNEL, cdcc_pkg::OP_READ_TOC, cdcc_pkg::OP_READ_HEADER,
      cdcc_pkg::OP_DISC_INFO, cdcc_pkg::OP_TRACK_INFO: needs_medium = 1'b1;
      default: needs_medium = 1'b0;
    endcase
  end

  logic [31:0] lba_short, lba_long, blocks;
  logic [32:0] lba_end;
  logic        out_of_range;

  assign lba_short = {11'd0, b1[4:0], b2, b3};
  assign lba_long  = {b2, b3, b4, b5};

  always_comb begin
    if (op == cdcc_pkg::OP_READ6) begin
      blocks = (b4 == 8'd0) ? 32'd256 : {24'd0, b4};
    end else if (op == cdcc_pkg::OP_READ10) begin
      blocks = {16'd0, b7, b8};
    end else begin
      blocks = {b6, b7, b8, b9};
    end
  end

  assign lba_end = {1'b0, ((op == cdcc_pkg::OP_READ6) ? lba_short : lba_long)}
                 + {1'b0, blocks};
  assign out_of_range = (((op == cdcc_pkg::OP_READ6) ? lba_short : lba_long) >= disc_blocks)
                     || (lba_end > {1'b0, disc_blocks});

  always_comb begin
    res = '0;
    if ((disc_blocks == 32'd0) && needs_medium) begin
      res.check_condition = 1'b1;
      res.sense           = '{key: cdcc_pkg::KEY_NOT_READY, code: cdcc_pkg::CODE_NO_MEDIUM};
    end else begin
      unique case (op) inside
        cdcc_pkg::OP_TEST_UNIT_READY, cdcc_pkg::OP_START_STOP, cdcc_pkg::OP_PREVENT,
        cdcc_pkg::OP_MODE_SENSE6, cdcc_pkg::OP_MODE_SENSE10, cdcc_pkg::OP_READ_CAPACITY,
        cdcc_pkg::OP_READ_TOC, cdcc_pkg::OP_READ_SUBCHANNEL, cdcc_pkg::OP_READ_HEADER,
        cdcc_pkg::OP_GET_CONFIG, cdcc_pkg::OP_EVENT_STATUS, cdcc_pkg::OP_DISC_INFO,
        cdcc_pkg::OP_TRACK_INFO, cdcc_pkg::OP_MECH_STATUS: begin
          res = '0;
        end
        cdcc_pkg::OP_INQUIRY: begin
          if (b1[0]) begin
            res.check_condition = 1'b1;
            res.sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_INV_FIELD};
          end
        end
        cdcc_pkg::OP_REQUEST_SENSE: begin
          res.sense       = held;
          res.data_in     = 1'b1;
          res.data_length = 25'(cdcc_pkg::SENSE_BYTES);
        end
        cdcc_pkg::OP_READ6, cdcc_pkg::OP_READ10, cdcc_pkg::OP_READ12: begin
          res.start_lba = (op == cdcc_pkg::OP_READ6) ? lba_short : lba_long;
          if (blocks != 32'd0) begin
            if (out_of_range) begin
              res.check_condition = 1'b1;
              res.sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_LBA_RANGE};
            end else if (blocks > 32'(cdcc_pkg::MAX_BLOCKS)) begin
              res.check_condition = 1'b1;
              res.sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_INV_FIELD};
            end else begin
              res.data_in     = 1'b1;
              res.block_count = blocks[13:0];
              res.data_length = 25'(blocks[13:0]) * 25'(cdcc_pkg::BLOCK_BYTES);
            end
          end
        end
        cdcc_pkg::OP_SEEK6, cdcc_pkg::OP_SEEK10: begin
          res.start_lba = (op == cdcc_pkg::OP_SEEK6) ? lba_short : lba_long;
          if (res.start_lba >= disc_blocks) begin
            res.check_condition = 1'b1;
            res.sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_LBA_RANGE};
          end
        end
        default: begin
          res.check_condition = 1'b1;
          res.sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_ILLEGAL_OP};
        end
      endcase
    end
  end

  // sense survives only a failing command
  assign held_next = res.check_condition ? res.sense : '0;

endmodule

/* rtl/cdrom_command_checker_core.sv */
// Top level of the CD-ROM command block checker: stream ports, APB register, pipeline.
//
// Usage: each input word on s_* carries one 12-byte command block; for every
// accepted word one result word appears on m_*, in order. The disc size is
// set through the APB port (register disc_blocks at address 0, zero means no
// disc); write it only while no command is in flight.
// Path: an accepted input word is held in the input register, then its result is
// written to the result register, which drives m_tvalid. Throughput: one word per
// cycle while m_tready is high; the decode and the held sense update sit in a single
// stage between the two registers.
// Stall: when m_tready is low the result register holds, the input register
// fills, and s_tready drops until the result is taken; no word is lost.
// Reset: both registers empty, held sense cleared, disc_blocks zero.
module cdrom_command_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] cdb_head, [95:64] cdb_tail
  input  logic [cdcc_pkg::IN_WIDTH-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] check_condition, [2:1] sense_key, [5:3] sense_code, [6] data_in,
  // [38:7] start_lba, [52:39] block_count, [77:53] data_length, [79:78] zero
  output logic [cdcc_pkg::OUT_WIDTH-1:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] disc_blocks;
  logic        in_valid;
  logic [cdcc_pkg::IN_WIDTH-1:0] in_word;
  logic        out_valid;
  cdcc_pkg::result_t res, res_q;
  cdcc_pkg::sense_t  held, held_next;
  logic        advance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cdcc_pkg::REG_DISC_BLOCKS) ? disc_blocks : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_blocks <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == cdcc_pkg::REG_DISC_BLOCKS) begin
      disc_blocks <= pwdata;
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata;
    end
  end

  cdcc_check u_check (
    .cdb_head   (in_word[63:0]),
    .cdb_tail   (in_word[95:64]),
    .disc_blocks(disc_blocks),
    .held       (held),
    .res        (res),
    .held_next  (held_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held      <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        held      <= held_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, res_q.data_length, res_q.block_count, res_q.start_lba,
                     res_q.data_in, res_q.sense.code, res_q.sense.key,
                     res_q.check_condition};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[6] && m_tdata[77:39] == '0)
    else $error("failed command carries data");

  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(held))
    else $error("held sense changed without a command");

  a_held_follows_fail: assert property (@(posedge clk) disable iff (rst)
    advance && !res.check_condition |=> held == '0)
    else $error("held sense kept after a passing command");

endmodule

/* sim/testbench.sv */
// Stream testbench for the CD-ROM command checker: predictor, driver, monitor and APB set-up.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [31:0] tail;
    logic [63:0] head;
  } cmd_t;

  localparam logic [20:0][7:0] KNOWN_OPS = {
    cdcc_pkg::OP_MECH_STATUS, cdcc_pkg::OP_READ12, cdcc_pkg::OP_MODE_SENSE10,
    cdcc_pkg::OP_TRACK_INFO, cdcc_pkg::OP_DISC_INFO, cdcc_pkg::OP_EVENT_STATUS,
    cdcc_pkg::OP_GET_CONFIG, cdcc_pkg::OP_READ_HEADER, cdcc_pkg::OP_READ_TOC,
    cdcc_pkg::OP_READ_SUBCHANNEL, cdcc_pkg::OP_SEEK10, cdcc_pkg::OP_READ10,
    cdcc_pkg::OP_READ_CAPACITY, cdcc_pkg::OP_PREVENT, cdcc_pkg::OP_START_STOP,
    cdcc_pkg::OP_MODE_SENSE6, cdcc_pkg::OP_INQUIRY, cdcc_pkg::OP_SEEK6,
    cdcc_pkg::OP_READ6, cdcc_pkg::OP_REQUEST_SENSE, cdcc_pkg::OP_TEST_UNIT_READY};
  localparam logic [31:0] TRIAL_DISC = 32'd9000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cmd_t              pending_cmds [$];
  cdcc_pkg::result_t expected_status [$];
  cdcc_pkg::sense_t  held_sense = '0;
  logic [31:0] disc_blocks_cfg = '0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          accepted_cmds = 0;
  int          err_count = 0;
  logic        recv_hold = 1'b0;

  cdrom_command_checker_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // status, sense and data phase for one command; updates the held sense
  function automatic cdcc_pkg::result_t predict_status(input cmd_t c);
    logic [7:0]  b [12];
    logic [7:0]  op;
    logic [31:0] lba;
    logic [31:0] blocks;
    logic [63:0] nbytes;
    logic        fail;
    logic        medium_op;
    cdcc_pkg::result_t r;
    int          i;
    for (i = 0; i < 8; i++) b[i] = c.head[63 - 8*i -: 8];
    for (i = 0; i < 4; i++) b[8 + i] = c.tail[31 - 8*i -: 8];
    op = b[0];
    lba = '0;
    blocks = '0;
    fail = 1'b0;
    r = '0;
    if (op != cdcc_pkg::OP_REQUEST_SENSE) held_sense = '0;
    case (op)
      cdcc_pkg::OP_TEST_UNIT_READY, cdcc_pkg::OP_READ_CAPACITY, cdcc_pkg::OP_READ6,
      cdcc_pkg::OP_READ10, cdcc_pkg::OP_READ12, cdcc_pkg::OP_SEEK6, cdcc_pkg::OP_SEEK10,
      cdcc_pkg::OP_READ_SUBCHANNEL, cdcc_pkg::OP_READ_TOC, cdcc_pkg::OP_READ_HEADER,
      cdcc_pkg::OP_DISC_INFO, cdcc_pkg::OP_TRACK_INFO: medium_op = 1'b1;
      default: medium_op = 1'b0;
    endcase
    if (medium_op && disc_blocks_cfg == 0) begin
      held_sense = '{key: cdcc_pkg::KEY_NOT_READY, code: cdcc_pkg::CODE_NO_MEDIUM};
      fail = 1'b1;
    end else begin
      case (op)
        cdcc_pkg::OP_TEST_UNIT_READY, cdcc_pkg::OP_START_STOP, cdcc_pkg::OP_PREVENT,
        cdcc_pkg::OP_MODE_SENSE6, cdcc_pkg::OP_MODE_SENSE10, cdcc_pkg::OP_READ_CAPACITY,
        cdcc_pkg::OP_READ_TOC, cdcc_pkg::OP_READ_SUBCHANNEL, cdcc_pkg::OP_READ_HEADER,
        cdcc_pkg::OP_GET_CONFIG, cdcc_pkg::OP_EVENT_STATUS, cdcc_pkg::OP_DISC_INFO,
        cdcc_pkg::OP_TRACK_INFO, cdcc_pkg::OP_MECH_STATUS: begin
        end
        cdcc_pkg::OP_INQUIRY: begin
          if (b[1][0]) begin
            held_sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_INV_FIELD};
            fail = 1'b1;
          end
        end
        cdcc_pkg::OP_REQUEST_SENSE: begin
          r.sense = held_sense;
          r.data_in = 1'b1;
          r.data_length = 25'(cdcc_pkg::SENSE_BYTES);
          held_sense = '0;
        end
        cdcc_pkg::OP_READ6, cdcc_pkg::OP_READ10, cdcc_pkg::OP_READ12: begin
          if (op == cdcc_pkg::OP_READ6) begin
            lba = {11'd0, b[1][4:0], b[2], b[3]};
            blocks = (b[4] != 0) ? {24'd0, b[4]} : 32'd256;
          end else begin
            lba = {b[2], b[3], b[4], b[5]};
            blocks = (op == cdcc_pkg::OP_READ10) ? {16'd0, b[7], b[8]}
                                                 : {b[6], b[7], b[8], b[9]};
          end
          nbytes = 64'(blocks) * 64'(cdcc_pkg::BLOCK_BYTES);
          if (blocks != 0) begin
            if (lba >= disc_blocks_cfg ||
                33'(lba) + 33'(blocks) > 33'(disc_blocks_cfg)) begin
              held_sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_LBA_RANGE};
              fail = 1'b1;
            end else if (nbytes > 64'(cdcc_pkg::MAX_TRANSFER_BYTES) ||
                         blocks > 32'(cdcc_pkg::MAX_READ_BLOCKS)) begin
              held_sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_INV_FIELD};
              fail = 1'b1;
            end else begin
              r.data_in = 1'b1;
              r.block_count = blocks[13:0];
              r.data_length = nbytes[24:0];
            end
          end
        end
        cdcc_pkg::OP_SEEK6, cdcc_pkg::OP_SEEK10: begin
          if (op == cdcc_pkg::OP_SEEK6) lba = {11'd0, b[1][4:0], b[2], b[3]};
          else lba = {b[2], b[3], b[4], b[5]};
          if (lba >= disc_blocks_cfg) begin
            held_sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_LBA_RANGE};
            fail = 1'b1;
          end
        end
        default: begin
          held_sense = '{key: cdcc_pkg::KEY_ILLEGAL, code: cdcc_pkg::CODE_ILLEGAL_OP};
          fail = 1'b1;
        end
      endcase
    end
    r.start_lba = lba;
    if (fail) begin
      r.check_condition = 1'b1;
      r.sense = held_sense;
      r.data_in = 1'b0;
      r.block_count = '0;
      r.data_length = '0;
    end
    return r;
  endfunction

  // command block with random filler; lba and count land where the opcode keeps them
  function automatic cmd_t make_cmd(input logic [7:0] op, input logic [31:0] lba,
                                    input logic [31:0] count);
    logic [7:0] b [12];
    cmd_t       c;
    int         i;
    for (i = 0; i < 12; i++) b[i] = 8'($urandom);
    b[0] = op;
    case (op)
      cdcc_pkg::OP_READ6, cdcc_pkg::OP_SEEK6: begin
        b[1][4:0] = lba[20:16];
        b[2] = lba[15:8];
        b[3] = lba[7:0];
        if (op == cdcc_pkg::OP_READ6) b[4] = count[7:0];
      end
      cdcc_pkg::OP_READ10, cdcc_pkg::OP_READ12, cdcc_pkg::OP_SEEK10: begin
        {b[2], b[3], b[4], b[5]} = lba;
        if (op == cdcc_pkg::OP_READ10) {b[7], b[8]} = count[15:0];
        else if (op == cdcc_pkg::OP_READ12) {b[6], b[7], b[8], b[9]} = count;
      end
      cdcc_pkg::OP_INQUIRY: b[1][0] = lba[0];
      default: begin
      end
    endcase
    c.head = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    c.tail = {b[8], b[9], b[10], b[11]};
    return c;
  endfunction

  // mostly well-formed commands aimed at the disc edges, some raw noise
  function automatic cmd_t random_cmd();
    logic [7:0]  op;
    logic [31:0] lba;
    logic [31:0] count;
    logic [31:0] d;
    int          pick;
    d = disc_blocks_cfg;
    pick = $urandom_range(99);
    if (pick < 8) return cmd_t'({$urandom, $urandom, $urandom});
    if (pick < 50) begin
      case ($urandom_range(2))
        0: op = cdcc_pkg::OP_READ6;
        1: op = cdcc_pkg::OP_READ10;
        default: op = cdcc_pkg::OP_READ12;
      endcase
    end else if (pick < 62) op = $urandom_range(1) ? cdcc_pkg::OP_SEEK6 : cdcc_pkg::OP_SEEK10;
    else if (pick < 72) op = cdcc_pkg::OP_REQUEST_SENSE;
    else if (pick < 80) op = cdcc_pkg::OP_INQUIRY;
    else op = KNOWN_OPS[$urandom_range(20)];
    case ($urandom_range(7))
      0: lba = '0;
      1: lba = d - 1;
      2: lba = d;
      3: lba = d - $urandom_range(300);
      4: lba = (d == 0) ? '0 : $urandom % d;
      5: lba = $urandom;
      6: lba = '1;
      default: lba = d + $urandom_range(3);
    endcase
    case ($urandom_range(8))
      0: count = '0;
      1: count = 32'd1;
      2: count = $urandom_range(300, 2);
      3: count = cdcc_pkg::MAX_READ_BLOCKS;
      4: count = cdcc_pkg::MAX_READ_BLOCKS + 1;
      5: count = d - lba;
      6: count = d - lba + 1;
      7: count = $urandom;
      default: count = $urandom_range(65535);
    endcase
    return make_cmd(op, lba, count);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 40)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // driver: one command word per handshake, prediction taken on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_status.push_back(predict_status(cmd_t'(s_tdata)));
        accepted_cmds++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_cmds.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: result word layout as on the m_tdata port
  always @(posedge clk) begin : result_check
    cdcc_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], '0);
        end else begin
          want = expected_status.pop_front();
          if (m_tdata[0] !== want.check_condition)
            report_mismatch("check_condition", m_tdata[0], want.check_condition);
          if (m_tdata[2:1] !== want.sense.key)
            report_mismatch("sense_key", m_tdata[2:1], want.sense.key);
          if (m_tdata[5:3] !== want.sense.code)
            report_mismatch("sense_code", m_tdata[5:3], want.sense.code);
          if (m_tdata[6] !== want.data_in)
            report_mismatch("data_in", m_tdata[6], want.data_in);
          if (m_tdata[38:7] !== want.start_lba)
            report_mismatch("start_lba", m_tdata[38:7], want.start_lba);
          if (m_tdata[52:39] !== want.block_count)
            report_mismatch("block_count", m_tdata[52:39], want.block_count);
          if (m_tdata[77:53] !== want.data_length)
            report_mismatch("data_length", m_tdata[77:53], want.data_length);
        end
      end
      m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall while the sender keeps offering words
  initial begin
    wait (accepted_cmds >= 150);
    @(negedge clk);
    recv_hold = 1'b1;
    repeat (300) @(negedge clk);
    recv_hold = 1'b0;
  end

  task automatic write_disc_blocks(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {cdcc_pkg::REG_DISC_BLOCKS, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    disc_blocks_cfg = value;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] disc, input int n);
    int k;
    write_disc_blocks(disc);
    for (k = 0; k < n; k++) pending_cmds.push_back(random_cmd());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 79;

    // no disc after reset
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_REQUEST_SENSE, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_TEST_UNIT_READY, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_REQUEST_SENSE, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ10, 32'd5, 32'd1));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_SEEK6, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_INQUIRY, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_INQUIRY, 32'd1, '0));
    pending_cmds.push_back(cmd_t'('1));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_MODE_SENSE6, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_REQUEST_SENSE, '0, '0));
    wait_drained();

    write_disc_blocks(TRIAL_DISC);
    pending_cmds.push_back(cmd_t'('0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ6, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ10, TRIAL_DISC - 1, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ12, '0, cdcc_pkg::MAX_READ_BLOCKS));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ12, '0,
                                    cdcc_pkg::MAX_READ_BLOCKS + 1));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_REQUEST_SENSE, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ10, TRIAL_DISC - 1, 32'd1));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ10, TRIAL_DISC - 1, 32'd2));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ12, '1, '1));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_SEEK6, 32'h001F_FFFF, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_SEEK10, TRIAL_DISC - 1, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_SEEK10, TRIAL_DISC, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_REQUEST_SENSE, '0, '0));
    pending_cmds.push_back(make_cmd(cdcc_pkg::OP_READ_CAPACITY, '0, '0));
    wait_drained();

    run_phase(TRIAL_DISC, 255);
    run_phase('1, 255);
    send_idle_pct = 79;
    recv_idle_pct = 20;
    run_phase(32'd1, 255);
    run_phase('0, 255);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(32'd300, 255);
    run_phase($urandom, 255);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
